// File: hdl/arsm_pkg.sv
`default_nettype none
package arsm_pkg;

   localparam int ElemW           = 64;
   localparam int AxisW           = 24;
   localparam int InnerCntW       = 11;
   localparam int CsrIdxW         = 2;
   localparam int CsrDataW        = 24;
   localparam int MaxInnerDefault = 1024;

   // register map
   typedef enum logic [CsrIdxW-1:0] {
      REG_REDUCE_KIND  = 2'd0,
      REG_ELEMENT_TYPE = 2'd1,
      REG_INNER_COUNT  = 2'd2,
      REG_AXIS_SIZE    = 2'd3
   } csr_index_type;

   // element type codes; 9..15 decode as u64
   localparam logic [3:0] ET_BOOL = 4'd0;
   localparam logic [3:0] ET_I8   = 4'd1;
   localparam logic [3:0] ET_U8   = 4'd2;
   localparam logic [3:0] ET_I16  = 4'd3;
   localparam logic [3:0] ET_U16  = 4'd4;
   localparam logic [3:0] ET_I32  = 4'd5;
   localparam logic [3:0] ET_U32  = 4'd6;
   localparam logic [3:0] ET_I64  = 4'd7;
   localparam logic [3:0] ET_U64  = 4'd8;

   localparam logic KIND_SUM = 1'b0;
   localparam logic KIND_MAX = 1'b1;

   typedef struct packed {
      logic             kind;
      logic [3:0]       etype;
      logic [AxisW-1:0] axis_last;
   } mode_type;

   function automatic logic [ElemW-1:0] elem_mask(input logic [3:0] et);
      logic [ElemW-1:0] m;
      unique case (et) inside
         ET_BOOL:       m = 64'h1;
         ET_I8, ET_U8:  m = 64'hFF;
         ET_I16, ET_U16: m = 64'hFFFF;
         ET_I32, ET_U32: m = 64'hFFFF_FFFF;
         default:       m = '1;
      endcase
      return m;
   endfunction

   // sign bit of signed types, zero for unsigned ones
   function automatic logic [ElemW-1:0] elem_signbit(input logic [3:0] et);
      logic [ElemW-1:0] s;
      unique case (et)
         ET_I8:   s = 64'h80;
         ET_I16:  s = 64'h8000;
         ET_I32:  s = 64'h8000_0000;
         ET_I64:  s = 64'h8000_0000_0000_0000;
         default: s = '0;
      endcase
      return s;
   endfunction

   function automatic logic [ElemW-1:0] elem_combine(input logic             kind,
                                                     input logic [3:0]       et,
                                                     input logic [ElemW-1:0] acc,
                                                     input logic [ElemW-1:0] v);
      logic [ElemW-1:0] mask;
      logic [ElemW-1:0] sb;
      logic [ElemW-1:0] r;
      mask = elem_mask(et);
      sb   = elem_signbit(et);
      if (et == ET_BOOL) begin
         r = (acc | v) & 64'h1;
      end else if (kind == KIND_SUM) begin
         r = (acc + v) & mask;
      end else begin
         r = ((v ^ sb) > (acc ^ sb)) ? v : acc;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: hdl/arsm_req_if.sv
`default_nettype none
interface arsm_req_if;
   import arsm_pkg::*;

   logic             valid;
   logic             ready;
   logic [ElemW-1:0] element;

   modport source (output valid, output element, input ready);
   modport sink   (input valid, input element, output ready);
endinterface
`default_nettype wire

// File: hdl/arsm_rsp_if.sv
`default_nettype none
interface arsm_rsp_if;
   import arsm_pkg::*;

   logic             valid;
   logic             ready;
   logic [ElemW-1:0] reduced_value;

   modport source (output valid, output reduced_value, input ready);
   modport sink   (input valid, input reduced_value, output ready);
endinterface
`default_nettype wire

// File: hdl/arsm_csr.sv
`default_nettype none
module arsm_csr #(
   parameter int MAX_INNER = arsm_pkg::MaxInnerDefault,
   localparam int AW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_we,
   input  wire [arsm_pkg::CsrIdxW-1:0]  csr_index,
   input  wire [arsm_pkg::CsrDataW-1:0] csr_wdata,
   output arsm_pkg::mode_type           mode,
   output logic [AW-1:0]                inner_last,
   output logic                         restart
);
   import arsm_pkg::*;

   logic                 kind_ff,  kind_in;
   logic [3:0]           etype_ff, etype_in;
   logic [InnerCntW-1:0] inner_ff, inner_in;
   logic [AxisW-1:0]     axis_ff,  axis_in;
   int unsigned          inner_eff;

   always_comb begin
      kind_in  = kind_ff;
      etype_in = etype_ff;
      inner_in = inner_ff;
      axis_in  = axis_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_REDUCE_KIND:  kind_in  = csr_wdata[0];
            REG_ELEMENT_TYPE: etype_in = csr_wdata[3:0];
            REG_INNER_COUNT:  inner_in = csr_wdata[InnerCntW-1:0];
            REG_AXIS_SIZE:    axis_in  = csr_wdata[AxisW-1:0];
            default:          kind_in  = kind_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_SUM;
         etype_ff <= ET_BOOL;
         inner_ff <= InnerCntW'(1);
         axis_ff  <= AxisW'(1);
      end else begin
         kind_ff  <= kind_in;
         etype_ff <= etype_in;
         inner_ff <= inner_in;
         axis_ff  <= axis_in;
      end
   end

   // zero counts act as one; inner count saturates at the table depth
   always_comb begin
      inner_eff = (inner_ff == '0) ? 32'd1 : 32'(inner_ff);
      if (inner_eff > 32'(MAX_INNER)) begin
         inner_eff = 32'(MAX_INNER);
      end
      inner_last     = AW'(inner_eff - 32'd1);
      mode.kind      = kind_ff;
      mode.etype     = etype_ff;
      mode.axis_last = (axis_ff == '0) ? '0 : axis_ff - AxisW'(1);
   end

   assign restart = csr_we;

endmodule
`default_nettype wire

// File: hdl/arsm_acc.sv
`default_nettype none
module arsm_acc #(
   parameter int MAX_INNER = arsm_pkg::MaxInnerDefault,
   localparam int AW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1
) (
   input  wire                         clock,
   input  wire                         reset,
   input  arsm_pkg::mode_type          mode,
   input  wire [AW-1:0]                inner_last,
   input  wire                         restart,
   arsm_req_if.sink                    req_chan,
   input  wire                         out_full,
   output logic                        out_push,
   output logic [arsm_pkg::ElemW-1:0]  out_value
);
   import arsm_pkg::*;

   // accumulator table
   logic [ElemW-1:0] acc_mem_ff [MAX_INNER];

   logic [AW-1:0]    ip_ff, ip_in;
   logic [AxisW-1:0] ap_ff, ap_in;

   logic             s1_valid_ff, s1_valid_in;
   logic [AW-1:0]    s1_addr_ff;
   logic             s1_first_ff;
   logic             s1_last_ff;
   logic [ElemW-1:0] s1_value_ff;
   logic [ElemW-1:0] rd_data_ff;

   logic             fwd_valid_ff;
   logic [AW-1:0]    fwd_addr_ff;
   logic [ElemW-1:0] fwd_data_ff;

   logic             accept;
   logic             s1_go;
   logic [ElemW-1:0] mask;
   logic [ElemW-1:0] old_acc;
   logic [ElemW-1:0] new_acc;

   assign mask           = elem_mask(mode.etype);
   assign s1_go          = s1_valid_ff && !(s1_last_ff && out_full);
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign accept         = req_chan.valid && req_chan.ready;

   // position counters, inner fastest
   always_comb begin
      ip_in = ip_ff;
      ap_in = ap_ff;
      if (restart) begin
         ip_in = '0;
         ap_in = '0;
      end else if (accept) begin
         if (ip_ff == inner_last) begin
            ip_in = '0;
            ap_in = (ap_ff == mode.axis_last) ? '0 : ap_ff + AxisW'(1);
         end else begin
            ip_in = ip_ff + AW'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_ff        <= '0;
         ap_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         ip_ff       <= ip_in;
         ap_ff       <= ap_in;
         s1_valid_ff <= s1_valid_in;
         if (s1_go) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   // stage 0: issue table read, latch beat
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff  <= ip_ff;
         s1_first_ff <= (ap_ff == '0);
         s1_last_ff  <= (ap_ff == mode.axis_last);
         s1_value_ff <= req_chan.element & mask;
         rd_data_ff  <= acc_mem_ff[ip_ff];
      end
   end

   // stage 1: combine and write back; last write is forwarded since the
   // next beat's read lands on the same edge as that write
   always_comb begin
      old_acc = (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) ? fwd_data_ff : rd_data_ff;
      old_acc = old_acc & mask;
      if (s1_first_ff) begin
         new_acc = s1_value_ff;
      end else begin
         new_acc = elem_combine(mode.kind, mode.etype, old_acc, s1_value_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         acc_mem_ff[s1_addr_ff] <= new_acc;
         fwd_addr_ff            <= s1_addr_ff;
         fwd_data_ff            <= new_acc;
      end
   end

   assign out_push  = s1_go && s1_last_ff;
   assign out_value = new_acc;

endmodule
`default_nettype wire

// File: hdl/arsm_obuf.sv
`default_nettype none
module arsm_obuf (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  wire [arsm_pkg::ElemW-1:0]  push_value,
   output logic                       full,
   arsm_rsp_if.source                 rsp_chan
);
   import arsm_pkg::*;

   // two-entry queue; full comes from registers only
   logic [ElemW-1:0] data0_ff, data0_in;
   logic [ElemW-1:0] data1_ff, data1_in;
   logic [1:0]       count_ff, count_in;
   logic             pop;

   assign rsp_chan.valid         = (count_ff != 2'd0);
   assign rsp_chan.reduced_value = data0_ff;
   assign pop                    = rsp_chan.valid && rsp_chan.ready;
   assign full                   = (count_ff == 2'd2);

   always_comb begin
      data0_in = data0_ff;
      data1_in = data1_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               data0_in = push_value;
            end else begin
               data1_in = push_value;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            data0_in = data1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               data0_in = push_value;
            end else begin
               data0_in = data1_ff;
               data1_in = push_value;
            end
         end
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      data0_ff <= data0_in;
      data1_ff <= data1_in;
   end

endmodule
`default_nettype wire

// File: hdl/axis_reduce_sum_max.sv
// Throughput: one element per cycle while no result beat meets a full queue, set by the single
//   accumulator table read-modify-write (read at accept, combine and write back as stage 1
//   advances and pushes any result into the queue, last write forwarded).
// Reset: synchronous, active high; clears registers to defaults, positions and queue.
//   The accumulator table is not cleared: position 0 of the axis always loads it first.
`default_nettype none
module axis_reduce_sum_max #(
   parameter int MAX_INNER = arsm_pkg::MaxInnerDefault
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_we,
   input  wire [arsm_pkg::CsrIdxW-1:0]  csr_index,
   input  wire [arsm_pkg::CsrDataW-1:0] csr_wdata,
   arsm_req_if.sink                     req_chan,
   arsm_rsp_if.source                   rsp_chan
);
   import arsm_pkg::*;

   localparam int AW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

   mode_type         mode;
   logic [AW-1:0]    inner_last;
   logic             restart;
   logic             out_full;
   logic             out_push;
   logic [ElemW-1:0] out_value;

   // config registers; any write restarts the stream at position zero
   arsm_csr #(
      .MAX_INNER (MAX_INNER)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mode       (mode),
      .inner_last (inner_last),
      .restart    (restart)
   );

   // position tracking plus two-stage accumulate over the table;
   // stalls only when a result beat has nowhere to go
   arsm_acc #(
      .MAX_INNER (MAX_INNER)
   ) u_acc (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode),
      .inner_last (inner_last),
      .restart    (restart),
      .req_chan   (req_chan),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_value  (out_value)
   );

   // two-entry result queue decouples rsp ready from req ready
   arsm_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .push       (out_push),
      .push_value (out_value),
      .full       (out_full),
      .rsp_chan   (rsp_chan)
   );

endmodule
`default_nettype wire

// File: verif/reduce_check_pkg.sv
`default_nettype none
package reduce_check_pkg;
   import arsm_pkg::*;

   // bit width of an element type; undefined codes act as 64-bit unsigned
   function automatic int unsigned type_width(logic [3:0] et);
      case (et)
         ET_BOOL:        return 1;
         ET_I8, ET_U8:   return 8;
         ET_I16, ET_U16: return 16;
         ET_I32, ET_U32: return 32;
         default:        return 64;
      endcase
   endfunction

   class reduction_tracker;
      logic [ElemW-1:0]     acc_table [MaxInnerDefault];
      int unsigned          inner_pos;
      int unsigned          axis_pos;
      logic                 kind;
      logic [3:0]           etype;
      logic [InnerCntW-1:0] inner_cnt;
      logic [AxisW-1:0]     axis_len;
      logic [ElemW-1:0]     expected_reductions [$];
      int unsigned          mismatches;

      function new();
         kind       = KIND_SUM;
         etype      = ET_BOOL;
         inner_cnt  = 1;
         axis_len   = 1;
         inner_pos  = 0;
         axis_pos   = 0;
         mismatches = 0;
      endfunction

      // any register write restarts the stream
      function void write_reg(csr_index_type idx, logic [CsrDataW-1:0] value);
         case (idx)
            REG_REDUCE_KIND:  kind      = value[0];
            REG_ELEMENT_TYPE: etype     = value[3:0];
            REG_INNER_COUNT:  inner_cnt = value[InnerCntW-1:0];
            REG_AXIS_SIZE:    axis_len  = value[AxisW-1:0];
            default: ;
         endcase
         inner_pos = 0;
         axis_pos  = 0;
      endfunction

      function void take_element(logic [ElemW-1:0] element);
         int unsigned      bits;
         int unsigned      n_inner;
         int unsigned      n_axis;
         logic [ElemW-1:0] mask;
         logic [ElemW-1:0] sign;
         logic [ElemW-1:0] v;
         logic [ElemW-1:0] acc;
         bits    = type_width(etype);
         mask    = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
         n_inner = (inner_cnt == 0) ? 1 :
                   (inner_cnt > MaxInnerDefault) ? MaxInnerDefault : inner_cnt;
         n_axis  = (axis_len == 0) ? 1 : axis_len;
         v       = element & mask;
         if (axis_pos == 0) begin
            acc = v;
         end else begin
            acc = acc_table[inner_pos] & mask;
            if (etype == ET_BOOL) begin
               acc = (acc | v) & 64'd1;
            end else if (kind == KIND_SUM) begin
               acc = (acc + v) & mask;
            end else begin
               // flip the sign bit so an unsigned compare orders signed values
               sign = (etype inside {ET_I8, ET_I16, ET_I32, ET_I64}) ?
                      (64'd1 << (bits - 1)) : '0;
               if ((v ^ sign) > (acc ^ sign)) acc = v;
            end
         end
         acc_table[inner_pos] = acc;
         if (axis_pos == n_axis - 1) expected_reductions.push_back(acc & mask);
         inner_pos++;
         if (inner_pos >= n_inner) begin
            inner_pos = 0;
            axis_pos++;
            if (axis_pos >= n_axis) axis_pos = 0;
         end
      endfunction

      function void check_reduction(logic [ElemW-1:0] got);
         logic [ElemW-1:0] want;
         if (expected_reductions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result beat %h with nothing expected", $realtime, got);
         end else begin
            want = expected_reductions.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: reduced_value expected %h, got %h", $realtime, want, got);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_reductions.size();
      endfunction
   endclass

endpackage
`default_nettype wire

// File: verif/tb.sv
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import arsm_pkg::*;
   import reduce_check_pkg::*;

   localparam int unsigned RandomItems  = 1250;
   localparam int unsigned SettleCycles = 4;     // result lags the last beat through stage 1 and the queue
   localparam int unsigned QuietLimit   = 5000;  // cycles with no beat and no write
   localparam logic [3:0]  ET_UNDEF_TOP = 4'hF;  // highest undefined type code

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   arsm_req_if req_chan ();
   arsm_rsp_if rsp_chan ();

   axis_reduce_sum_max uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   reduction_tracker tracker = new();

   // idle odds in percent, changed between phases of the run
   int unsigned send_gap_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned quiet_cycles  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: ready is redrawn at every falling edge.
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Monitor: everything is sampled at the rising edge. Accepted elements feed
   // the predictor, accepted results are checked in order, register writes
   // update the predictor's copy of the configuration. The watchdog counts
   // cycles in which nothing at all moves.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) tracker.take_element(req_chan.element);
         if (rsp_chan.valid && rsp_chan.ready) tracker.check_reduction(rsp_chan.reduced_value);
         if (csr_we) tracker.write_reg(csr_index_type'(csr_index), csr_wdata);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) || csr_we)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("%0t: no beat for %0d cycles", $realtime, QuietLimit);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // One register write: enable for a single cycle.
   task automatic set_reg(csr_index_type idx, logic [CsrDataW-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Offer one element beat, with random gaps ahead of it; returns at the
   // rising edge that accepts it. valid stays up into the next beat.
   task automatic push_element(logic [ElemW-1:0] value);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid   <= 1'b0;
         req_chan.element <= {$urandom, $urandom};
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.element <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Stop sending and wait until every expected result is in, then let the
   // pipe empty out (a partial reduction may still be in flight).
   task automatic drain(int unsigned extra);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // When configure is set, program all four registers (junk in the unused upper
   // data bits), then stream the given beats and drain.
   task automatic run_phase(bit configure, logic kind, logic [3:0] etype,
                            logic [InnerCntW-1:0] inner, logic [AxisW-1:0] axis_len,
                            logic [ElemW-1:0] beats [$], bit pause_midway);
      logic [CsrDataW-1:0] junk;
      junk = $urandom;
      if (configure) begin
         set_reg(REG_REDUCE_KIND,  {junk[CsrDataW-1:1], kind});
         set_reg(REG_ELEMENT_TYPE, {junk[CsrDataW-1:4], etype});
         set_reg(REG_INNER_COUNT,  {junk[CsrDataW-1:InnerCntW], inner});
         set_reg(REG_AXIS_SIZE,    axis_len);
      end
      foreach (beats[i]) begin
         push_element(beats[i]);
         // sender holds off until the block has caught up completely
         if (pause_midway && i == beats.size() / 2) drain(0);
      end
      drain(SettleCycles);
   endtask

   // Random element, biased toward the edges of the type: zero, all ones,
   // most negative and most positive. Upper unused bits carry junk.
   function automatic logic [ElemW-1:0] pick_element(logic [3:0] etype);
      logic [ElemW-1:0] junk;
      logic [ElemW-1:0] top;
      logic [ElemW-1:0] ones;
      junk = {$urandom, $urandom};
      top  = 64'd1 << (type_width(etype) - 1);
      ones = (top << 1) - 64'd1;
      case ($urandom_range(5))
         2:       return (junk & ~ones) | top;
         3:       return (junk & ~ones) | (top - 64'd1);
         4:       return junk | ones;
         5:       return junk & ~ones;
         default: return junk;
      endcase
   endfunction

   initial begin
      logic [ElemW-1:0]     beats [$];
      int unsigned          random_items;
      int unsigned          phase_no;
      int unsigned          tensor;
      int unsigned          n;
      logic                 kind;
      logic [3:0]           etype;
      logic [InnerCntW-1:0] inner;
      logic [AxisW-1:0]     axis_len;

      // every input known from time zero
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = REG_REDUCE_KIND;
      csr_wdata        = '0;
      req_chan.valid   = 1'b0;
      req_chan.element = '0;
      rsp_chan.ready   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_gap_pct  = 22;
      rsp_stall_pct = 76;

      // ---- directed part ----
      // reset defaults: bool sum, single position, axis of one; only bit 0 counts
      beats = '{64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE};
      run_phase(1'b0, KIND_SUM, ET_BOOL, 11'd1, 24'd1, beats, 1'b0);
      // bool max is an OR; zero inner count acts as one
      beats = '{64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFE, 64'd1};
      run_phase(1'b1, KIND_MAX, ET_BOOL, 11'd0, 24'd2, beats, 1'b0);
      // signed 8-bit max: -128 vs 127, then -1 vs -128; junk above bit 7
      beats = '{64'hA5A5_0000_0000_0080, 64'h0000_0000_0000_007F,
                64'h0000_0000_0000_00FF, 64'h5A00_0000_0000_0080};
      run_phase(1'b1, KIND_MAX, ET_I8, 11'd1, 24'd2, beats, 1'b0);
      // undefined type code behaves as u64; inner count above the table
      // saturates; zero axis size acts as one
      beats = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd0};
      run_phase(1'b1, KIND_MAX, ET_UNDEF_TOP, 11'h7FF, 24'd0, beats, 1'b0);
      // 16-bit sum across two positions: wraps to 0x8000 and to zero
      beats = '{64'h7FFF, 64'hFFFF, 64'd1, 64'd1};
      run_phase(1'b1, KIND_SUM, ET_I16, 11'd2, 24'd2, beats, 1'b0);
      // unsigned 8-bit sum wraps to zero
      beats = '{64'hFF, 64'h01};
      run_phase(1'b1, KIND_SUM, ET_U8, 11'd1, 24'd2, beats, 1'b0);
      // partial i64 reduction, dropped by the register writes that follow
      beats = '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF};
      run_phase(1'b1, KIND_MAX, ET_I64, 11'd1, 24'd3, beats, 1'b0);
      beats = '{64'd1, 64'h8000_0000_0000_0000};
      run_phase(1'b1, KIND_MAX, ET_I64, 11'd1, 24'd2, beats, 1'b0);

      // ---- random part ----
      random_items = 0;
      phase_no     = 0;
      while (random_items < RandomItems) begin
         // idle mix: slow receiver, then slow sender, then full speed
         case (random_items * 3 / RandomItems)
            0:       begin send_gap_pct = 22; rsp_stall_pct = 76; end
            1:       begin send_gap_pct = 76; rsp_stall_pct = 22; end
            default: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
         endcase

         kind  = $urandom_range(1);
         etype = ($urandom_range(9) == 0) ? $urandom_range(ET_UNDEF_TOP, ET_U64 + 1)
                                         : $urandom_range(ET_U64);
         case ($urandom_range(19))
            0: begin
               // widest table, axis of one: every beat is a result
               inner    = $urandom_range(1) ? 11'h7FF : 11'd1024;
               axis_len = 1;
               n        = $urandom_range(40, 16);
            end
            1: begin
               // very long axis: never completes, broken off by the next writes
               inner    = $urandom_range(3) == 0 ? 11'd1024 : $urandom_range(3, 1);
               axis_len = $urandom_range(1) ? 24'hFF_FFFF : $urandom_range(24'hFF_FFFF, 24'h80_0000);
               n        = $urandom_range(12, 4);
            end
            default: begin
               inner    = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
               axis_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
               tensor   = (inner == 0 ? 1 : inner) * (axis_len == 0 ? 1 : axis_len);
               n        = tensor * $urandom_range(4, 1);
               // sometimes stop short of a whole tensor
               if (tensor > 1 && $urandom_range(5) == 0) n -= $urandom_range(tensor - 1, 1);
            end
         endcase

         beats.delete();
         repeat (n) beats.push_back(pick_element(etype));
         run_phase(1'b1, kind, etype, inner, axis_len, beats, (phase_no % 5) == 0);
         random_items += n;
         phase_no++;
      end

      // all results in; keep watching to catch any stray beat
      drain(SettleCycles * 4);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
`default_nettype wire
